/* rtl/core/cthc_pkg.sv */
// Shared types, codes and constants for the compact target hash check.
// Used by the channel interfaces, both pipeline stages, the top level and the checker.
package cthc_pkg;

   localparam int WORD_BITS_DEFAULT = 64;
   localparam int TARGET_W          = 256;
   localparam int COMPACT_W         = 32;
   localparam int LIMIT_W           = 64;
   localparam int LIMIT_WORDS       = 4;
   localparam int CSR_INDEX_W       = 2;
   localparam int STATUS_W          = 2;
   localparam int ORDER_W           = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT_WORD3 = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT_WORD2 = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT_WORD1 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT_WORD0 = 2'd3;

   localparam logic [LIMIT_W-1:0] LIMIT_WORD3_RESET = 64'h0000_0000_FFFF_FFFF;
   localparam logic [LIMIT_W-1:0] LIMIT_LOWER_RESET = 64'hFFFF_FFFF_FFFF_FFFF;

   localparam logic [STATUS_W-1:0] STATUS_PASS     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INVALID  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_MISMATCH = 2'd2;

   localparam logic [ORDER_W-1:0] ORDER_EQUAL   = 2'd0;
   localparam logic [ORDER_W-1:0] ORDER_GREATER = 2'd1;
   localparam logic [ORDER_W-1:0] ORDER_LESS    = 2'd2;

   typedef struct packed {
      logic valid;
      logic last;
      logic active;
   } stage_ctrl_type;

   // Expands the compact form into the full target; shifts past the top give zero.
   function automatic logic [TARGET_W-1:0] decode_compact(input logic [COMPACT_W-1:0] compact);
      logic [7:0]          expo;
      logic [TARGET_W-1:0] mant;
      expo = compact[31:24];
      mant = TARGET_W'(compact[22:0]);
      if (expo < 8'd3) begin
         return mant >> {(8'd3 - expo), 3'b000};
      end else begin
         return mant << {(expo - 8'd3), 3'b000};
      end
   endfunction

endpackage

/* rtl/core/cthc_req_if.sv */
// Request channel of the compact target hash check: one hash word per request.
// Depends on cthc_pkg for the default word width and the compact width.
interface cthc_req_if #(
   parameter int WORD_BITS = cthc_pkg::WORD_BITS_DEFAULT
) ();
   logic                             valid;
   logic                             ready;
   logic [WORD_BITS-1:0]             hash_word;
   logic [cthc_pkg::COMPACT_W-1:0]   compact_target;
   logic                             last_word;

   modport source (output valid, hash_word, compact_target, last_word, input ready);
   modport sink   (input valid, hash_word, compact_target, last_word, output ready);
endinterface

/* rtl/core/cthc_rsp_if.sv */
// Result channel of the compact target hash check: one status per hash.
// Depends on cthc_pkg for the status width.
interface cthc_rsp_if ();
   logic                            valid;
   logic                            ready;
   logic [cthc_pkg::STATUS_W-1:0]   status;

   modport source (output valid, status, input ready);
   modport sink   (input valid, status, output ready);
endinterface

/* rtl/core/cthc_input_stage.sv */
// Input register stage: accepts hash words, tracks the word position and
// holds the decoded target of the current hash. Depends on cthc_pkg and cthc_req_if.
module cthc_input_stage #(
   parameter int WORD_BITS = cthc_pkg::WORD_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   cthc_req_if.sink                               req_chan,
   input  logic                                   go,
   output cthc_pkg::stage_ctrl_type               ctrl,
   output logic [WORD_BITS-1:0]                   item_word,
   output logic [$clog2(cthc_pkg::TARGET_W / WORD_BITS)-1:0] item_index,
   output logic [cthc_pkg::TARGET_W-1:0]          item_target,
   output logic [cthc_pkg::COMPACT_W-1:0]         item_compact
);
   import cthc_pkg::*;

   localparam int WORDS = TARGET_W / WORD_BITS;
   localparam int POS_W = $clog2(WORDS + 1);
   localparam int IDX_W = $clog2(WORDS);

   logic [POS_W-1:0]      pos_ff, pos_in;
   stage_ctrl_type        ctrl_ff, ctrl_in;
   logic [WORD_BITS-1:0]  word_ff;
   logic [IDX_W-1:0]      index_ff;
   logic [TARGET_W-1:0]   target_ff;
   logic [COMPACT_W-1:0]  compact_ff;
   logic                  accept;
   logic                  first;
   logic                  active;

   assign req_chan.ready = !ctrl_ff.valid || go;
   assign accept         = req_chan.valid && req_chan.ready;
   assign first          = (pos_ff == '0);
   assign active         = (pos_ff < POS_W'(WORDS));

   always_comb begin
      pos_in  = pos_ff;
      ctrl_in = ctrl_ff;
      if (accept) begin
         if (req_chan.last_word) begin
            pos_in = '0;
         end else if (active) begin
            pos_in = pos_ff + 1'b1;
         end
         ctrl_in.valid  = 1'b1;
         ctrl_in.last   = req_chan.last_word;
         ctrl_in.active = active;
      end else if (go) begin
         ctrl_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         ctrl_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff  <= req_chan.hash_word;
         index_ff <= pos_ff[IDX_W-1:0];
         if (first) begin
            target_ff  <= decode_compact(req_chan.compact_target);
            compact_ff <= req_chan.compact_target;
         end
      end
   end

   assign ctrl         = ctrl_ff;
   assign item_word    = word_ff;
   assign item_index   = index_ff;
   assign item_target  = target_ff;
   assign item_compact = compact_ff;

endmodule

/* rtl/core/cthc_compare_stage.sv */
// Compare stage: running hash and limit comparisons, limit registers and
// the result register. Depends on cthc_pkg and cthc_rsp_if.
module cthc_compare_stage #(
   parameter int WORD_BITS = cthc_pkg::WORD_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  cthc_pkg::stage_ctrl_type               ctrl,
   input  logic [WORD_BITS-1:0]                   item_word,
   input  logic [$clog2(cthc_pkg::TARGET_W / WORD_BITS)-1:0] item_index,
   input  logic [cthc_pkg::TARGET_W-1:0]          item_target,
   input  logic [cthc_pkg::COMPACT_W-1:0]         item_compact,
   input  logic                                   csr_write_enable,
   input  logic [cthc_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [cthc_pkg::LIMIT_W-1:0]           csr_write_data,
   output logic                                   go,
   cthc_rsp_if.source                             rsp_chan
);
   import cthc_pkg::*;

   localparam int WORDS    = TARGET_W / WORD_BITS;
   localparam int COVER_LO = TARGET_W - WORDS * WORD_BITS;

   logic [LIMIT_W-1:0]   limit_ff [LIMIT_WORDS];
   logic [TARGET_W-1:0]  limit_all;
   logic [ORDER_W-1:0]   hvt_ff, hvt_in, hvt_cur;
   logic [ORDER_W-1:0]   tvl_ff, tvl_in, tvl_cur;
   logic                 seen_ff, seen_in, seen_cur;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic                 advance;
   logic [7:0]           chunk_lo;
   logic [WORD_BITS-1:0] target_chunk;
   logic [WORD_BITS-1:0] limit_chunk;
   logic [TARGET_W-1:0]  tail_mask;
   logic [TARGET_W-1:0]  tail_target;
   logic [TARGET_W-1:0]  tail_limit;
   logic                 above_limit;
   logic                 seen_final;
   logic [7:0]           expo;
   logic [22:0]          mant;
   logic                 overflow;
   logic                 negative;

   assign limit_all = {limit_ff[CSR_LIMIT_WORD3], limit_ff[CSR_LIMIT_WORD2],
                       limit_ff[CSR_LIMIT_WORD1], limit_ff[CSR_LIMIT_WORD0]};

   assign go      = !ctrl.last || !rsp_valid_ff || rsp_chan.ready;
   assign advance = ctrl.valid && go;

   always_comb begin
      chunk_lo     = 8'(TARGET_W - (int'(item_index) + 1) * WORD_BITS);
      target_chunk = item_target[chunk_lo +: WORD_BITS];
      limit_chunk  = limit_all[chunk_lo +: WORD_BITS];
      hvt_cur      = hvt_ff;
      tvl_cur      = tvl_ff;
      seen_cur     = seen_ff;
      tail_mask    = '0;
      if (ctrl.active) begin
         if (hvt_ff == ORDER_EQUAL) begin
            if (item_word > target_chunk) begin
               hvt_cur = ORDER_GREATER;
            end else if (item_word < target_chunk) begin
               hvt_cur = ORDER_LESS;
            end
         end
         if (tvl_ff == ORDER_EQUAL) begin
            if (target_chunk > limit_chunk) begin
               tvl_cur = ORDER_GREATER;
            end else if (target_chunk < limit_chunk) begin
               tvl_cur = ORDER_LESS;
            end
         end
         seen_cur  = seen_ff || (target_chunk != '0);
         tail_mask = ~({TARGET_W{1'b1}} << chunk_lo) & ({TARGET_W{1'b1}} << COVER_LO);
      end

      // Words never received count as zero, so only the target and limit
      // tails below the current chunk still matter on the final word.
      tail_target = item_target & tail_mask;
      tail_limit  = limit_all & tail_mask;
      above_limit = (tvl_cur == ORDER_GREATER) ||
                    ((tvl_cur == ORDER_EQUAL) && (tail_target > tail_limit));
      seen_final  = seen_cur || (tail_target != '0);

      expo     = item_compact[31:24];
      mant     = item_compact[22:0];
      overflow = (mant != '0) && ((expo > 8'd34) ||
                 ((mant > 23'd255) && (expo > 8'd33)) ||
                 ((mant > 23'd65535) && (expo > 8'd32)));
      negative = seen_final && item_compact[23];

      if (negative || !seen_final || overflow || above_limit) begin
         status_in = STATUS_INVALID;
      end else if (hvt_cur == ORDER_GREATER) begin
         status_in = STATUS_MISMATCH;
      end else begin
         status_in = STATUS_PASS;
      end
   end

   always_comb begin
      hvt_in       = hvt_ff;
      tvl_in       = tvl_ff;
      seen_in      = seen_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (advance) begin
         if (ctrl.last) begin
            hvt_in       = ORDER_EQUAL;
            tvl_in       = ORDER_EQUAL;
            seen_in      = 1'b0;
            rsp_valid_in = 1'b1;
         end else begin
            hvt_in  = hvt_cur;
            tvl_in  = tvl_cur;
            seen_in = seen_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hvt_ff       <= ORDER_EQUAL;
         tvl_ff       <= ORDER_EQUAL;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hvt_ff       <= hvt_in;
         tvl_ff       <= tvl_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && ctrl.last) begin
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff[CSR_LIMIT_WORD3] <= LIMIT_WORD3_RESET;
         limit_ff[CSR_LIMIT_WORD2] <= LIMIT_LOWER_RESET;
         limit_ff[CSR_LIMIT_WORD1] <= LIMIT_LOWER_RESET;
         limit_ff[CSR_LIMIT_WORD0] <= LIMIT_LOWER_RESET;
      end else if (csr_write_enable) begin
         limit_ff[csr_index] <= csr_write_data;
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = status_ff;

endmodule

/* rtl/core/compact_target_hash_check.sv */
// The block takes one hash word per cycle unless stalled. The final word of a hash is
// held in the input register, which feeds a single compare pass whose outcome lands in
// the result register, which drives the status. Requests keep flowing while a status
// waits; only a final word stalls, and only when the previous status has not been taken.
// The limit registers may be written only while no request is in flight.
module compact_target_hash_check #(
   parameter int WORD_BITS = cthc_pkg::WORD_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   cthc_req_if.sink                          req_chan,
   cthc_rsp_if.source                        rsp_chan,
   input  logic                              csr_write_enable,
   input  logic [cthc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [cthc_pkg::LIMIT_W-1:0]      csr_write_data
);
   import cthc_pkg::*;

   localparam int IDX_W = $clog2(TARGET_W / WORD_BITS);

   stage_ctrl_type        ctrl;
   logic [WORD_BITS-1:0]  item_word;
   logic [IDX_W-1:0]      item_index;
   logic [TARGET_W-1:0]   item_target;
   logic [COMPACT_W-1:0]  item_compact;
   logic                  go;

   cthc_input_stage #(.WORD_BITS(WORD_BITS)) u_input (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .go           (go),
      .ctrl         (ctrl),
      .item_word    (item_word),
      .item_index   (item_index),
      .item_target  (item_target),
      .item_compact (item_compact)
   );

   cthc_compare_stage #(.WORD_BITS(WORD_BITS)) u_compare (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .item_word        (item_word),
      .item_index       (item_index),
      .item_target      (item_target),
      .item_compact     (item_compact),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .go               (go),
      .rsp_chan         (rsp_chan)
   );

endmodule

/* rtl/core/cthc_checker.sv */
// Port-level assertions for the compact target hash check, bound to the top level.
// Depends on cthc_pkg for the status codes.
module cthc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [cthc_pkg::STATUS_W-1:0]   rsp_status
);
   import cthc_pkg::*;

   status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_PASS || rsp_status == STATUS_INVALID ||
                     rsp_status == STATUS_MISMATCH))
      else $error("Status code outside the defined set.");

   reset_clears_result: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Result still valid after reset.");

   stall_only_on_full_output: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("Request stalled while the result register could move.");

   result_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)))
      else $error("Pending result dropped or changed.");

endmodule

bind compact_target_hash_check cthc_checker u_cthc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_status (rsp_chan.status)
);

/* test/compact_target_hash_check_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for compact_target_hash_check: streams hash words and compact targets,
// predicts each unpinned status in step with the accepted requests and checks the result stream.
// Depends on cthc_pkg, the cthc_req_if and cthc_rsp_if interfaces and the block itself.
module compact_target_hash_check_test;
   import cthc_pkg::*;

   localparam int CHUNK_W         = 64;
   localparam int PHASES          = 8;
   localparam int WORDS_PER_PHASE = 240;
   localparam int SETTLE_CYCLES   = 6;
   localparam int STALL_LIMIT     = 3000;
   localparam int SCRIPT_ROWS     = 25;

   typedef struct packed {
      logic [CHUNK_W-1:0]   hash_word;
      logic [COMPACT_W-1:0] compact;
      logic                 last;
      logic                 pinned;
      logic [STATUS_W-1:0]  status;
   } script_row_type;

   localparam logic [CHUNK_W-1:0] ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [CHUNK_W-1:0] ZERO  = 64'h0;
   localparam logic [COMPACT_W-1:0] GENESIS = 32'h1D00_FFFF;

   localparam script_row_type SCRIPT [SCRIPT_ROWS] = '{
      '{ZERO, 32'h0000_0000, 1'b1, 1'b1, STATUS_INVALID},
      '{ZERO, 32'h0492_3456, 1'b1, 1'b1, STATUS_INVALID},
      '{ZERO, 32'h2300_0001, 1'b1, 1'b1, STATUS_INVALID},
      '{ZERO, 32'h2200_0100, 1'b1, 1'b1, STATUS_INVALID},
      '{ZERO, 32'h2101_0000, 1'b1, 1'b1, STATUS_INVALID},
      '{ZERO, 32'h0100_3456, 1'b1, 1'b1, STATUS_INVALID},
      '{ONES, 32'hFFFF_FFFF, 1'b1, 1'b1, STATUS_INVALID},
      '{ONES, GENESIS,       1'b0, 1'b0, STATUS_PASS},
      '{ONES, 32'hFFFF_FFFF, 1'b0, 1'b0, STATUS_PASS},
      '{ONES, 32'hFFFF_FFFF, 1'b0, 1'b0, STATUS_PASS},
      '{ONES, 32'h0000_0000, 1'b1, 1'b1, STATUS_MISMATCH},
      '{ZERO, GENESIS,       1'b0, 1'b0, STATUS_PASS},
      '{ZERO, 32'h0000_0000, 1'b0, 1'b0, STATUS_PASS},
      '{ZERO, 32'h0000_0000, 1'b0, 1'b0, STATUS_PASS},
      '{ZERO, 32'h0000_0000, 1'b1, 1'b1, STATUS_PASS},
      '{ZERO, 32'h1D01_FFFF, 1'b1, 1'b1, STATUS_INVALID},
      '{64'h0000_0000_FFFF_0000, GENESIS, 1'b0, 1'b0, STATUS_PASS},
      '{ZERO, 32'h0000_0000, 1'b0, 1'b0, STATUS_PASS},
      '{ZERO, 32'h0000_0000, 1'b0, 1'b0, STATUS_PASS},
      '{ZERO, 32'h0000_0000, 1'b1, 1'b0, STATUS_PASS},
      '{ZERO, GENESIS,       1'b0, 1'b0, STATUS_PASS},
      '{ZERO, 32'h0000_0000, 1'b0, 1'b0, STATUS_PASS},
      '{ZERO, 32'h0000_0000, 1'b0, 1'b0, STATUS_PASS},
      '{ZERO, 32'h0000_0000, 1'b0, 1'b0, STATUS_PASS},
      '{ONES, 32'h0000_0000, 1'b1, 1'b0, STATUS_PASS}
   };

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [LIMIT_W-1:0]     csr_write_data;

   cthc_req_if #(.WORD_BITS(CHUNK_W)) req_bus ();
   cthc_rsp_if rsp_bus ();

   compact_target_hash_check #(.WORD_BITS(CHUNK_W)) uut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   logic [LIMIT_W-1:0]   limit_words [LIMIT_WORDS];
   int                   words_seen;
   logic [COMPACT_W-1:0] cur_compact;
   logic [ORDER_W-1:0]   hash_order;
   logic [ORDER_W-1:0]   limit_order;
   logic                 target_nonzero;

   logic [STATUS_W-1:0]  expected_status [$];
   int                   send_idle_pct;
   int                   recv_stall_pct;
   int                   idle_cycles;
   int                   mismatch_count;
   int                   word_count;
   int                   status_tally [3];
   int                   setting_count;
   logic [COMPACT_W-1:0] near_compact;
   logic                 near_active;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [TARGET_W-1:0] expand_target(input logic [COMPACT_W-1:0] compact);
      int                  shift;
      logic [TARGET_W-1:0] mant;
      mant  = TARGET_W'(compact[22:0]);
      shift = 8 * int'(compact[31:24]) - 24;
      if (shift >= 0) begin
         return mant << shift;
      end else begin
         return mant >> (-shift);
      end
   endfunction

   function automatic logic [ORDER_W-1:0] order_of(input logic [ORDER_W-1:0] prev,
                                                  input logic [CHUNK_W-1:0] a,
                                                  input logic [CHUNK_W-1:0] b);
      if (prev != ORDER_EQUAL) begin
         return prev;
      end
      if (a > b) begin
         return ORDER_GREATER;
      end
      if (a < b) begin
         return ORDER_LESS;
      end
      return ORDER_EQUAL;
   endfunction

   function automatic logic [TARGET_W-1:0] random_wide();
      logic [TARGET_W-1:0] r;
      for (int i = 0; i < TARGET_W / 32; i++) begin
         r[32*i +: 32] = $urandom;
      end
      return r;
   endfunction

   function automatic logic [TARGET_W-1:0] low_mask(input int bits);
      if (bits >= TARGET_W) begin
         return '1;
      end
      return (TARGET_W'(1) << bits) - TARGET_W'(1);
   endfunction

   function automatic logic [COMPACT_W-1:0] pick_valid_compact();
      logic [7:0]  expo;
      logic [22:0] mant;
      expo = 8'($urandom_range(0, 34));
      mant = 23'($urandom) >> $urandom_range(0, 22);
      if (expo == 8'd34) begin
         mant = mant & 23'hFF;
      end else if (expo == 8'd33) begin
         mant = mant & 23'hFFFF;
      end
      return {expo, 1'b0, mant};
   endfunction

   task automatic fold_chunk(input int slot, input logic [CHUNK_W-1:0] hash_chunk);
      logic [TARGET_W-1:0] full;
      logic [CHUNK_W-1:0]  target_chunk;
      full = expand_target(cur_compact);
      target_chunk = full[TARGET_W-1-CHUNK_W*slot -: CHUNK_W];
      hash_order  = order_of(hash_order, hash_chunk, target_chunk);
      limit_order = order_of(limit_order, target_chunk, limit_words[slot]);
      if (target_chunk != '0) begin
         target_nonzero = 1'b1;
      end
   endtask

   task automatic fold_word(input logic [CHUNK_W-1:0] hash_word,
                            input logic [COMPACT_W-1:0] compact, input logic last,
                            output logic made, output logic [STATUS_W-1:0] status);
      logic [7:0]  expo;
      logic [22:0] mant;
      logic        overflow;
      logic        negative;
      made   = 1'b0;
      status = STATUS_PASS;
      if (words_seen == 0) begin
         cur_compact = compact;
      end
      if (words_seen < LIMIT_WORDS) begin
         fold_chunk(words_seen, hash_word);
         words_seen++;
      end
      if (last) begin
         while (words_seen < LIMIT_WORDS) begin
            fold_chunk(words_seen, '0);
            words_seen++;
         end
         expo = cur_compact[31:24];
         mant = cur_compact[22:0];
         overflow = (mant != '0) && (expo > 8'd34 || (mant > 23'hFF && expo > 8'd33) ||
                                     (mant > 23'hFFFF && expo > 8'd32));
         negative = target_nonzero && cur_compact[23];
         if (negative || !target_nonzero || overflow || limit_order == ORDER_GREATER) begin
            status = STATUS_INVALID;
         end else if (hash_order == ORDER_GREATER) begin
            status = STATUS_MISMATCH;
         end
         made           = 1'b1;
         words_seen     = 0;
         cur_compact    = '0;
         hash_order     = ORDER_EQUAL;
         limit_order    = ORDER_EQUAL;
         target_nonzero = 1'b0;
      end
   endtask

   task automatic send_word(input logic [CHUNK_W-1:0] hash_word,
                            input logic [COMPACT_W-1:0] compact, input logic last,
                            input logic pinned, input logic [STATUS_W-1:0] pin_status);
      logic                made;
      logic [STATUS_W-1:0] predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.hash_word      <= hash_word;
      req_bus.compact_target <= compact;
      req_bus.last_word      <= last;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      fold_word(hash_word, compact, last, made, predicted);
      if (made) begin
         expected_status.push_back(pinned ? pin_status : predicted);
      end
      word_count++;
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (expected_status.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [CSR_INDEX_W-1:0] index,
                              input logic [LIMIT_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      limit_words[index] = data;
      @(posedge clock);
   endtask

   task automatic apply_limit(input int phase);
      logic [TARGET_W-1:0] limit_value;
      near_active = 1'b0;
      case (phase)
         0, 7: begin
            limit_value = {LIMIT_WORD3_RESET, LIMIT_LOWER_RESET, LIMIT_LOWER_RESET,
                           LIMIT_LOWER_RESET};
         end
         1: begin
            limit_value = '1;
         end
         3: begin
            limit_value = '0;
         end
         5: begin
            limit_value = random_wide();
         end
         default: begin
            near_compact = pick_valid_compact();
            near_active  = 1'b1;
            limit_value  = expand_target(near_compact) ^
                           (random_wide() & low_mask($urandom_range(0, 200)));
         end
      endcase
      write_limit(CSR_LIMIT_WORD3, limit_value[255:192]);
      write_limit(CSR_LIMIT_WORD2, limit_value[191:128]);
      write_limit(CSR_LIMIT_WORD1, limit_value[127:64]);
      write_limit(CSR_LIMIT_WORD0, limit_value[63:0]);
      csr_write_enable <= 1'b0;
      setting_count++;
   endtask

   task automatic report_mismatch(input string text);
      if (mismatch_count < 10) begin
         $display("Mismatch at %0t: %s", $realtime, text);
      end
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      logic [STATUS_W-1:0] want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_status.size() == 0) begin
            report_mismatch($sformatf("status %0d with none expected", rsp_bus.status));
         end else begin
            want = expected_status.pop_front();
            if (rsp_bus.status !== want) begin
               report_mismatch($sformatf("status expected %0d, got %0d", want,
                                         rsp_bus.status));
            end
            if (want <= STATUS_MISMATCH) begin
               status_tally[want]++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == STALL_LIMIT) begin
         $display("Timeout: no request or result moved for %0d cycles", STALL_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      logic [COMPACT_W-1:0] compact;
      logic [TARGET_W-1:0]  hash_value;
      int                   phase_words;
      int                   length;
      int                   pick;
      reset                  = 1'b1;
      csr_write_enable       = 1'b0;
      csr_index              = CSR_LIMIT_WORD3;
      csr_write_data         = '0;
      req_bus.valid          = 1'b0;
      req_bus.hash_word      = '0;
      req_bus.compact_target = '0;
      req_bus.last_word      = 1'b0;
      rsp_bus.ready          = 1'b0;
      limit_words[0]         = LIMIT_WORD3_RESET;
      limit_words[1]         = LIMIT_LOWER_RESET;
      limit_words[2]         = LIMIT_LOWER_RESET;
      limit_words[3]         = LIMIT_LOWER_RESET;
      words_seen             = 0;
      cur_compact            = '0;
      hash_order             = ORDER_EQUAL;
      limit_order            = ORDER_EQUAL;
      target_nonzero         = 1'b0;
      send_idle_pct          = 0;
      recv_stall_pct         = 0;
      idle_cycles            = 0;
      mismatch_count         = 0;
      word_count             = 0;
      status_tally           = '{0, 0, 0};
      setting_count          = 1;
      near_compact           = '0;
      near_active            = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int row = 0; row < SCRIPT_ROWS; row++) begin
         send_word(SCRIPT[row].hash_word, SCRIPT[row].compact, SCRIPT[row].last,
                   SCRIPT[row].pinned, SCRIPT[row].status);
      end
      settle();

      for (int phase = 0; phase < PHASES; phase++) begin
         apply_limit(phase);
         case (phase % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 72;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 72;
            end
            default: begin
               send_idle_pct  = 22;
               recv_stall_pct = 22;
            end
         endcase
         phase_words = 0;
         while (phase_words < WORDS_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               compact = (near_active && $urandom_range(0, 2) == 0) ? near_compact :
                         pick_valid_compact();
            end else if (pick < 75) begin
               compact = pick_valid_compact() | 32'h0080_0000;
            end else if (pick < 90) begin
               compact = $urandom;
            end else begin
               compact = {8'($urandom_range(32, 40)), 24'($urandom) >> $urandom_range(0, 23)};
            end
            if ($urandom_range(0, 9) < 8) begin
               hash_value = expand_target(compact) ^
                            (random_wide() & low_mask($urandom_range(0, TARGET_W)));
            end else begin
               hash_value = random_wide();
            end
            length = ($urandom_range(0, 99) < 75) ? LIMIT_WORDS : $urandom_range(1, 7);
            for (int w = 0; w < length; w++) begin
               send_word((w < LIMIT_WORDS) ? hash_value[TARGET_W-1-CHUNK_W*w -: CHUNK_W] :
                                             {$urandom, $urandom},
                         (w == 0) ? compact : COMPACT_W'($urandom),
                         (w == length - 1), 1'b0, STATUS_PASS);
            end
            phase_words += length;
         end
         settle();
      end

      $display("Run sent %0d hash words under %0d limit settings, with sender and receiver idling.",
               word_count, setting_count);
      $display("Statuses checked: %0d pass, %0d invalid target, %0d hash above target.",
               status_tally[0], status_tally[1], status_tally[2]);
      if (mismatch_count == 0 && expected_status.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
